/* rtl/pcd_pkg.sv */
// Shared types and constants for the prefix code table decoder.
package pcd_pkg;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int IDX_W  = 6;
	localparam int STAT_W = 2;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_SYMBOL   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd1;
	localparam logic [STAT_W-1:0] STAT_LEFTOVER = 2'd2;

	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic resolve;
		logic push;
	} ctl_t;

	typedef struct packed {
		logic search_end;
		logic produce;
	} sts_t;

endpackage

/* rtl/pcd_if.sv */
// Request and result channel interfaces for the prefix code table decoder.
interface pcd_req_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [pcd_pkg::IDX_W-1:0]    entry_index;
	logic [pcd_pkg::SYM_W-1:0]    entry_symbol;
	logic [pcd_pkg::CODE_W-1:0]   entry_code;
	logic [pcd_pkg::LEN_W-1:0]    entry_length;
	logic                         coded_bit;
	logic                         stream_end;

	modport source (output valid, command, entry_index, entry_symbol, entry_code,
		entry_length, coded_bit, stream_end, input ready);
	modport sink (input valid, command, entry_index, entry_symbol, entry_code,
		entry_length, coded_bit, stream_end, output ready);
endinterface

interface pcd_res_if;
	logic                         valid;
	logic                         ready;
	logic [pcd_pkg::SYM_W-1:0]    symbol;
	logic [pcd_pkg::STAT_W-1:0]   status;

	modport source (output valid, symbol, status, input ready);
	modport sink (input valid, symbol, status, output ready);
endinterface

/* rtl/pcd_ctrl.sv */
// Sequencer for the prefix code table decoder: request handshake, search and result hand-off.
module pcd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_decode,
	output logic          req_ready,
	input  logic          res_ready,
	output logic          res_valid,
	input  pcd_pkg::sts_t sts,
	output pcd_pkg::ctl_t ctl
);
	import pcd_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       res_valid_q;
	logic       accept;
	logic       slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid & req_ready;
	assign slot_free = ~res_valid_q | res_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_decode == CMD_DECODE) begin
						ctl.start = 1'b1;
						state_d   = ST_SEARCH;
					end else begin
						ctl.load = 1'b1;
					end
				end
			end
			ST_SEARCH: begin
				ctl.step = 1'b1;
				if (sts.search_end) begin
					ctl.resolve = 1'b1;
					state_d     = sts.produce ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					ctl.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/pcd_datapath.sv */
// Code table memory, bit accumulator, entry compare and result registers.
module pcd_datapath #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pcd_pkg::ctl_t               ctl,
	output pcd_pkg::sts_t               sts,
	input  logic [pcd_pkg::IDX_W-1:0]   entry_index,
	input  logic [pcd_pkg::SYM_W-1:0]   entry_symbol,
	input  logic [pcd_pkg::CODE_W-1:0]  entry_code,
	input  logic [pcd_pkg::LEN_W-1:0]   entry_length,
	input  logic                        coded_bit,
	input  logic                        stream_end,
	output logic [pcd_pkg::SYM_W-1:0]   symbol,
	output logic [pcd_pkg::STAT_W-1:0]  status
);
	import pcd_pkg::*;

	localparam int IW  = $clog2(TABLE_ENTRIES);
	localparam int AW  = ((IW > IDX_W) ? IW : IDX_W) + 1;
	localparam int CNW = $clog2(MAX_CODE_BITS + 1);
	localparam int CMW = ((CNW > LEN_W) ? CNW : LEN_W) + 1;
	localparam int PW  = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;

	entry_t                   mem [TABLE_ENTRIES];
	entry_t                   ent_s1;
	logic [TABLE_ENTRIES-1:0] loaded_q;
	logic [MAX_CODE_BITS-1:0] pend_bits_q;
	logic [CNW-1:0]           pend_cnt_q;
	logic                     end_q;
	logic [IW-1:0]            rd_idx_q;
	logic [IW-1:0]            cmp_idx_s1;
	logic                     cmp_vld_s1;
	logic [SYM_W-1:0]         res_sym_q;
	logic [STAT_W-1:0]        res_stat_q;
	logic [SYM_W-1:0]         out_sym_q;
	logic [STAT_W-1:0]        out_stat_q;

	logic [AW-1:0]            idx_ext;
	logic                     wr_en;
	logic [IW-1:0]            wr_addr;
	logic [MAX_CODE_BITS:0]   shifted;
	logic [PW-1:0]            len_mask;
	logic                     ent_loaded;
	logic                     len_eq;
	logic                     bits_eq;
	logic                     hit;
	logic                     last;
	logic                     too_long;

	assign idx_ext = AW'(entry_index);
	assign wr_en   = ctl.load & (idx_ext < AW'(TABLE_ENTRIES));
	assign wr_addr = idx_ext[IW-1:0];
	assign shifted = {pend_bits_q, coded_bit};

	assign len_mask   = ~({PW{1'b1}} << ent_s1.len);
	assign ent_loaded = loaded_q[cmp_idx_s1];
	assign len_eq     = (CMW'(ent_s1.len) == CMW'(pend_cnt_q));
	assign bits_eq    = ((PW'(ent_s1.code) & len_mask) == PW'(pend_bits_q));
	assign hit        = ent_loaded & len_eq & bits_eq;
	assign last       = (cmp_idx_s1 == IW'(TABLE_ENTRIES - 1));
	assign too_long   = (pend_cnt_q == CNW'(MAX_CODE_BITS));

	assign sts.search_end = cmp_vld_s1 & (~ent_loaded | hit | last);
	assign sts.produce    = hit | too_long | end_q;

	assign symbol = out_sym_q;
	assign status = out_stat_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{sym: entry_symbol, code: entry_code, len: entry_length};
		end
		ent_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			if (wr_en) begin
				loaded_q[wr_addr] <= 1'b1;
			end
			if (ctl.start) begin
				pend_bits_q <= shifted[MAX_CODE_BITS-1:0];
				if (pend_cnt_q != CNW'(MAX_CODE_BITS)) begin
					pend_cnt_q <= pend_cnt_q + CNW'(1);
				end
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (ctl.step) begin
				rd_idx_q   <= rd_idx_q + IW'(1);
				cmp_vld_s1 <= ~sts.search_end;
			end
			if (ctl.resolve && sts.produce) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			end_q <= stream_end;
		end
		if (ctl.step) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (ctl.resolve) begin
			res_sym_q <= hit ? ent_s1.sym : '0;
			if (hit) begin
				res_stat_q <= STAT_SYMBOL;
			end else if (too_long) begin
				res_stat_q <= STAT_TOO_LONG;
			end else begin
				res_stat_q <= STAT_LEFTOVER;
			end
		end
		if (ctl.push) begin
			out_sym_q  <= res_sym_q;
			out_stat_q <= res_stat_q;
		end
	end

endmodule

/* rtl/prefix_code_table_decoder.sv */
// Top level of the prefix code table decoder with a loadable code table.
//
//   port    dir   carries
//   req     sink  load entry (index, symbol, code, length) or one decode bit + end mark
//   result  src   decoded symbol and status (symbol, too long, leftover bits)
//
// A load request is written into the table as it is accepted. A decode request is
// accepted, the first entry is fetched and then one table entry after another is
// inspected, stopping at the first unloaded slot, a match or the last slot; a result,
// if one is produced, goes to the output register once that register is free. The pace
// is set by the single read port of the table memory. Reset clears loaded flags and the
// bit accumulator; table contents are undefined until loaded. A stalled result holds
// in the output register while the next request is taken.
module prefix_code_table_decoder #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	pcd_req_if.sink   req,
	pcd_res_if.source result
);
	import pcd_pkg::*;

	ctl_t ctl;
	sts_t sts;

	pcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_decode (req.command),
		.req_ready  (req.ready),
		.res_ready  (result.ready),
		.res_valid  (result.valid),
		.sts        (sts),
		.ctl        (ctl)
	);

	pcd_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.entry_index  (req.entry_index),
		.entry_symbol (req.entry_symbol),
		.entry_code   (req.entry_code),
		.entry_length (req.entry_length),
		.coded_bit    (req.coded_bit),
		.stream_end   (req.stream_end),
		.symbol       (result.symbol),
		.status       (result.status)
	);

endmodule

/* rtl/pcd_checker.sv */
// Port-level checks for the prefix code table decoder, bound to the top level.
module pcd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_command,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [pcd_pkg::SYM_W-1:0]   symbol,
	input logic [pcd_pkg::STAT_W-1:0]  status
);
	import pcd_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(symbol) && $stable(status))
		else $error("result changed while stalled");

	a_error_no_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STAT_SYMBOL |-> symbol == '0)
		else $error("error result carries a symbol");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command == CMD_DECODE |=> !req_ready)
		else $error("ready right after a decode request");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command == CMD_LOAD |=> req_ready)
		else $error("not ready after a load request");

	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!req_ready))
		else $error("result appeared without a search");

endmodule

bind prefix_code_table_decoder pcd_checker u_pcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_command  (req.command),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.symbol       (result.symbol),
	.status       (result.status)
);

/* test/tb_prefix_code_table_decoder.sv */
// Self-checking testbench for the prefix code table decoder: table loads and bit-serial decode.
module tb_prefix_code_table_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import pcd_pkg::*;

	localparam int SLOTS = 64;
	localparam int MAX_BITS = 32;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 80;

	typedef struct {
		logic              command;
		logic [IDX_W-1:0]  entry_index;
		logic [SYM_W-1:0]  entry_symbol;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0]  entry_length;
		logic              coded_bit;
		logic              stream_end;
	} request_t;

	typedef struct {
		logic [SYM_W-1:0]  symbol;
		logic [STAT_W-1:0] status;
	} outcome_t;

	logic clk;
	logic arst_n;

	pcd_req_if req_bus ();
	pcd_res_if res_bus ();

	prefix_code_table_decoder #(
		.TABLE_ENTRIES(SLOTS),
		.MAX_CODE_BITS(MAX_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.result(res_bus)
	);

	// decoder state as seen by the testbench
	logic [SYM_W-1:0]  tbl_sym[SLOTS];
	logic [CODE_W-1:0] tbl_code[SLOTS];
	logic [LEN_W-1:0]  tbl_len[SLOTS];
	bit                tbl_loaded[SLOTS];
	logic [CODE_W-1:0] acc_bits;
	int                acc_count;

	outcome_t outcome_queue[$];
	int error_count;
	int requests_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_request;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void apply_request(input request_t r);
		outcome_t res;
		logic [63:0] mask;
		bit hit;
		bit emit;
		int i;
		if (r.command == CMD_LOAD) begin
			if (int'(r.entry_index) < SLOTS) begin
				tbl_sym[r.entry_index] = r.entry_symbol;
				tbl_code[r.entry_index] = r.entry_code;
				tbl_len[r.entry_index] = r.entry_length;
				tbl_loaded[r.entry_index] = 1'b1;
			end
			return;
		end
		acc_bits = {acc_bits[CODE_W-2:0], r.coded_bit};
		if (acc_count < MAX_BITS)
			acc_count++;
		hit = 1'b0;
		emit = 1'b0;
		i = 0;
		// search stops at the first slot never loaded
		while (!hit && i < SLOTS && tbl_loaded[i]) begin
			mask = (64'd1 << tbl_len[i]) - 64'd1;
			if (tbl_len[i] != 0 && tbl_len[i] <= MAX_BITS && int'(tbl_len[i]) == acc_count &&
					(tbl_code[i] & mask[CODE_W-1:0]) == acc_bits) begin
				hit = 1'b1;
				res.symbol = tbl_sym[i];
				res.status = STAT_SYMBOL;
			end
			i++;
		end
		emit = hit;
		if (!hit && acc_count >= MAX_BITS) begin
			res.symbol = '0;
			res.status = STAT_TOO_LONG;
			emit = 1'b1;
		end else if (!hit && r.stream_end) begin
			res.symbol = '0;
			res.status = STAT_LEFTOVER;
			emit = 1'b1;
		end
		if (emit) begin
			acc_bits = '0;
			acc_count = 0;
			outcome_queue.push_back(res);
		end
	endfunction

	function automatic logic [LEN_W-1:0] junk_length();
		if ($urandom_range(1) == 0)
			return '0;
		return LEN_W'($urandom_range(63, MAX_BITS + 1));
	endfunction

	task automatic send_request(input request_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_bus.valid <= 1'b1;
		req_bus.command <= r.command;
		req_bus.entry_index <= r.entry_index;
		req_bus.entry_symbol <= r.entry_symbol;
		req_bus.entry_code <= r.entry_code;
		req_bus.entry_length <= r.entry_length;
		req_bus.coded_bit <= r.coded_bit;
		req_bus.stream_end <= r.stream_end;
		do @(posedge clk); while (!req_bus.ready);
		apply_request(r);
		requests_sent++;
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		request_t r;
		r.command = CMD_LOAD;
		r.entry_index = idx;
		r.entry_symbol = sym;
		r.entry_code = code;
		r.entry_length = len;
		r.coded_bit = 1'($urandom);
		r.stream_end = 1'($urandom);
		send_request(r);
	endtask

	task automatic decode_bit(input logic b, input logic last);
		request_t r;
		r.command = CMD_DECODE;
		r.entry_index = IDX_W'($urandom);
		r.entry_symbol = SYM_W'($urandom);
		r.entry_code = $urandom;
		r.entry_length = LEN_W'($urandom);
		r.coded_bit = b;
		r.stream_end = last;
		send_request(r);
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (outcome_queue.size() != 0);
	endtask

	task automatic test_special_cases();
		decode_bit(1'b1, 1'b1);                      // empty table: leftover
		load_entry(0, 8'hFF, 32'hFFFF_FFFE, 1);      // "0", upper code bits ignored
		load_entry(1, 8'h00, 32'h0000_0002, 2);      // "10"
		load_entry(2, 8'h11, 32'h0000_0002, 2);      // duplicate of slot 1
		load_entry(3, 8'h22, 32'h0000_0000, 0);
		load_entry(4, 8'h33, 32'hFFFF_FFFF, 33);
		load_entry(5, 8'h44, 32'h0000_0003, 63);
		load_entry(8, 8'h55, 32'h0000_0003, 2);      // "11" behind a gap
		load_entry(63, 8'hAA, 32'h0000_0007, 3);
		decode_bit(1'b0, 1'b0);
		decode_bit(1'b1, 1'b0);
		decode_bit(1'b0, 1'b0);
		decode_bit(1'b1, 1'b0);
		decode_bit(1'b1, 1'b1);
		decode_bit(1'b0, 1'b1);                      // match on the final bit
		load_entry(6, 8'h5A, 32'h0000_0000, 0);      // close the gap
		load_entry(7, 8'hA5, 32'hFFFF_FFFF, 40);
		decode_bit(1'b1, 1'b0);
		decode_bit(1'b1, 1'b0);
		load_entry(1, 8'h66, 32'h0000_0002, 2);      // overwrite slot 1
		decode_bit(1'b1, 1'b0);
		decode_bit(1'b0, 1'b0);
	endtask

	task automatic test_long_codes();
		logic [CODE_W-1:0] words[3];
		bit ends[3];
		int j;
		int w;
		words = '{32'h5A5A_5A5A, 32'h5A5A_5A5B, 32'h0000_0000};
		ends = '{1'b1, 1'b0, 1'b1};
		load_entry(0, 8'hC3, 32'h5A5A_5A5A, 32);
		// full-length match, then too long, then too long on an end bit
		for (w = 0; w < 3; w++)
			for (j = CODE_W - 1; j >= 0; j--)
				decode_bit(words[w][j], ends[w] && j == 0);
	endtask

	task automatic test_random_streams(input int item_budget);
		logic [CODE_W-1:0] leaf_code[$];
		int leaf_len[$];
		bit stream[$];
		logic [CODE_W-1:0] code_word;
		int first_count;
		int n_codes;
		int missing;
		int deep;
		int pick;
		int cut;
		int j;
		bit end_mark;
		first_count = requests_sent;
		while (requests_sent - first_count < item_budget) begin
			// random complete prefix code by splitting leaves
			n_codes = ($urandom_range(7) == 0) ? $urandom_range(60, 24) : $urandom_range(12, 2);
			leaf_code = {32'd0, 32'd1};
			leaf_len = {1, 1};
			while (leaf_code.size() < n_codes) begin
				j = $urandom_range(leaf_code.size() - 1);
				if ($urandom_range(3) == 0) begin
					deep = 0;
					foreach (leaf_len[k])
						if (leaf_len[k] > leaf_len[deep])
							deep = k;
					j = deep;
				end
				if (leaf_len[j] < MAX_BITS) begin
					leaf_code.push_back({leaf_code[j][CODE_W-2:0], 1'b1});
					leaf_len.push_back(leaf_len[j] + 1);
					leaf_code[j] = leaf_code[j] << 1;
					leaf_len[j]++;
				end
			end
			missing = ($urandom_range(3) == 0) ? $urandom_range(n_codes - 1) : -1;
			for (j = 0; j < n_codes; j++) begin
				code_word = $urandom;
				code_word = (code_word << leaf_len[j]) | leaf_code[j];
				if (j == missing)
					load_entry(IDX_W'(j), SYM_W'($urandom), code_word, junk_length());
				else
					load_entry(IDX_W'(j), SYM_W'($urandom), code_word, LEN_W'(leaf_len[j]));
			end
			// disable stale usable slots past the new code
			for (j = n_codes; j < SLOTS; j++)
				if (tbl_loaded[j] && tbl_len[j] != 0 && tbl_len[j] <= MAX_BITS)
					load_entry(IDX_W'(j), SYM_W'($urandom), $urandom, junk_length());
			if ($urandom_range(7) == 0)
				load_entry(IDX_W'($urandom), SYM_W'($urandom), $urandom, LEN_W'($urandom));
			stream.delete();
			repeat ($urandom_range(12, 3)) begin
				pick = $urandom_range(n_codes - 1);
				for (j = leaf_len[pick] - 1; j >= 0; j--)
					stream.push_back(leaf_code[pick][j] ^ ($urandom_range(31) == 0));
			end
			if ($urandom_range(5) == 0) begin
				cut = $urandom_range(3, 1);
				while (cut > 0 && stream.size() > 1) begin
					void'(stream.pop_back());
					cut--;
				end
			end
			end_mark = ($urandom_range(3) != 0);
			foreach (stream[k])
				decode_bit(stream[k], end_mark && k == stream.size() - 1);
		end
	endtask

	task automatic test_backpressure();
		load_entry(0, SYM_W'($urandom), 32'h0000_0000, 1);
		load_entry(1, SYM_W'($urandom), 32'h0000_0001, 1);
		stall_request = 400;
		repeat (40)
			decode_bit(1'($urandom), 1'($urandom));
		wait_drained();
	endtask

	// result side: checks each accepted result and drives ready
	initial begin : result_side
		outcome_t want;
		int stall_left;
		stall_left = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready) begin
				if (outcome_queue.size() == 0) begin
					$display("%0t: unexpected result: symbol %0h status %0d", $time,
						res_bus.symbol, res_bus.status);
					error_count++;
				end else begin
					want = outcome_queue.pop_front();
					if (res_bus.symbol !== want.symbol) begin
						$display("%0t: symbol mismatch: expected %0h actual %0h", $time,
							want.symbol, res_bus.symbol);
						error_count++;
					end
					if (res_bus.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d", $time,
							want.status, res_bus.status);
						error_count++;
					end
				end
			end
			if (stall_request != 0) begin
				stall_left = stall_request;
				stall_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("prefix_code_table_decoder test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.command = CMD_LOAD;
		req_bus.entry_index = '0;
		req_bus.entry_symbol = '0;
		req_bus.entry_code = '0;
		req_bus.entry_length = '0;
		req_bus.coded_bit = 1'b0;
		req_bus.stream_end = 1'b0;
		acc_bits = '0;
		acc_count = 0;
		error_count = 0;
		requests_sent = 0;
		stall_request = 0;
		idle_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 82;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_special_cases();
		test_long_codes();
		test_random_streams(600);
		wait_drained();

		send_idle_pct = 82;
		recv_idle_pct = 22;
		test_random_streams(600);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_streams(600);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (outcome_queue.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, outcome_queue.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("prefix_code_table_decoder test passed");
		end else begin
			$display("prefix_code_table_decoder test failed");
		end
		$finish;
	end

endmodule
